// ----- design/sopg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sopg_pkg: shared types and constants of the spiral orbit position generator
// widths of the datapath, the cordic arctangent table and register indexes
// ----------------------------------------------------------------------------
package sopg_pkg;

  // field widths
  localparam int PW = 24;           // Q16.8 position
  localparam int AW = 32;           // angle, 2^32 per turn
  localparam int SW = 32;           // Q16.16 scale
  localparam int XW = 36;           // cordic x/y with 8 guard bits and growth
  localparam int ZW = 33;           // cordic residual angle
  localparam int GW = 28;           // gain-corrected offset
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES = 24;

  // 1/K of the cordic gain in Q.24
  localparam logic signed [24:0] GAIN_Q24 = 25'sd10188014;

  localparam logic signed [SW-1:0] SCALE_ONE = 32'sd65536;

  // round-to-nearest arctangent, 2^-32 turn units
  localparam logic [29:0] ATAN_TURN [ATAN_ENTRIES] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
    30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
    30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
    30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
  };

  typedef enum logic [CFG_IW-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_START_X    = 3'd2,
    REG_START_Y    = 3'd3,
    REG_ANGLE_STEP = 3'd4,
    REG_SCALE_STEP = 3'd5,
    REG_CLOCKWISE  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic restart;
  } in_item_t;

  typedef struct packed {
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
  } out_item_t;

  // data handed from cell to cell
  typedef struct packed {
    logic                 vld;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

endpackage

// ----- design/sopg_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sopg_chan_if: valid/ready channel
// one payload per transfer, taken when valid and ready are both high
// ----------------------------------------------------------------------------
interface sopg_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/spiral_orbit_position_generator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiral_orbit_position_generator_unit: per-frame orbit position generator
// steps a frame count and a running scale on each tick, rotates the start
// offset about the pivot through a chain of cordic cells, scales it and
// adds the pivot back
// ----------------------------------------------------------------------------
//
//  channel | dir | payload              | meaning
//  --------+-----+----------------------+---------------------------------
//  in_ch   | in  | restart              | one frame tick, or restart
//  out_ch  | out | pos_x, pos_y (Q16.8) | new target position, one per tick
//  cfg_*   | in  | index 0..6, data     | pivot, start, steps, direction
//
//  one item is in flight at a time; a result reaches the output register
//  through the tick and angle registers, the first cell register, the cell
//  chain and the gain and scale stages
//  a new item is taken as soon as the previous result sits in the output
//  register, so a waiting result does not block the input
//  when out_ch stalls with a result waiting and another one arrives, the
//  whole chain holds
//  synchronous active-low reset: count 0, scale 1.0, registers 0, no items
//
module spiral_orbit_position_generator_unit #(
  parameter int CORDIC_STAGES = sopg_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sopg_chan_if.sink                     in_ch,
  sopg_chan_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [sopg_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [sopg_pkg::CFG_DW-1:0]   cfg_data
);
  import sopg_pkg::*;

  // stages past the arctangent table are not performed
  localparam int NS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int XPAD = XW - 34;

  // configuration registers
  logic signed [PW-1:0] center_x_r, center_y_r, start_x_r, start_y_r;
  logic [AW-1:0]        angle_step_r;
  logic signed [SW-1:0] scale_step_r;
  logic                 clockwise_r;

  // frame state
  logic [AW-1:0]        count_r, count_nxt;
  logic signed [SW-1:0] scale_r, scale_nxt;
  logic signed [SW:0]   scale_sum;

  // control
  logic                 busy_r;
  logic                 in_xfer, adv, out_load;
  logic                 tick_vld_r;
  logic                 ang_vld_r;
  logic [AW-1:0]        angle_r;

  // quadrant pre-rotation
  logic [AW-1:0]        ang_sh, res;
  logic [1:0]           quad;
  logic signed [PW:0]   off_x, off_y;
  logic signed [PW+1:0] px, py;
  cordic_t              pre_nxt;
  cordic_t              chain [NS+1];

  // result
  logic                 fin_vld;
  out_item_t            fin;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  // ---- configuration writes ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= '0;
      center_y_r   <= '0;
      start_x_r    <= '0;
      start_y_r    <= '0;
      angle_step_r <= '0;
      scale_step_r <= '0;
      clockwise_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:   center_x_r   <= cfg_data[PW-1:0];
        REG_CENTER_Y:   center_y_r   <= cfg_data[PW-1:0];
        REG_START_X:    start_x_r    <= cfg_data[PW-1:0];
        REG_START_Y:    start_y_r    <= cfg_data[PW-1:0];
        REG_ANGLE_STEP: angle_step_r <= cfg_data[AW-1:0];
        REG_SCALE_STEP: scale_step_r <= cfg_data[SW-1:0];
        REG_CLOCKWISE:  clockwise_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---- handshake control ----
  assign in_ch.ready = !busy_r;
  assign in_xfer     = in_ch.valid && !busy_r;
  // the chain holds only when a finished result meets a full output register that out_ch is not taking
  assign adv         = !(fin_vld && out_valid_r && !out_ch.ready);
  assign out_load    = fin_vld && adv;

  // ---- frame state update on each transfer ----
  always_comb begin
    scale_sum = {scale_r[SW-1], scale_r} + {scale_step_r[SW-1], scale_step_r};
    if (in_ch.data.restart) begin
      count_nxt = '0;
      scale_nxt = SCALE_ONE;
    end else begin
      // saturate the running scale to the signed 32-bit range
      if (scale_sum[SW] != scale_sum[SW-1]) begin
        scale_nxt = scale_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
        scale_nxt = scale_sum[SW-1:0];
      end
      count_nxt = clockwise_r ? count_r - 1'b1 : count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      scale_r     <= SCALE_ONE;
      busy_r      <= 1'b0;
      tick_vld_r  <= 1'b0;
      ang_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_r <= count_nxt;
        scale_r <= scale_nxt;
      end
      if (in_xfer) begin
        busy_r <= 1'b1;
      end else if (out_load) begin
        busy_r <= 1'b0;
      end
      // angle is taken in the cycle after the count has been stepped
      if (adv) begin
        tick_vld_r <= in_xfer;
        ang_vld_r  <= tick_vld_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- angle: count times step, wraps modulo one turn ----
  always_ff @(posedge clk) begin
    if (adv) begin
      angle_r <= count_r * angle_step_r;
    end
  end

  // ---- quadrant pre-rotation into the first cell ----
  always_comb begin
    ang_sh = angle_r + 32'h2000_0000;
    quad   = ang_sh[AW-1:AW-2];
    // residual within one eighth of a turn either way
    res    = angle_r - {quad, {(AW-2){1'b0}}};
    off_x  = {start_x_r[PW-1], start_x_r} - {center_x_r[PW-1], center_x_r};
    off_y  = {start_y_r[PW-1], start_y_r} - {center_y_r[PW-1], center_y_r};
    case (quad)
      2'd1: begin
        px = -{off_y[PW], off_y};
        py =  {off_x[PW], off_x};
      end
      2'd2: begin
        px = -{off_x[PW], off_x};
        py = -{off_y[PW], off_y};
      end
      2'd3: begin
        px =  {off_y[PW], off_y};
        py = -{off_x[PW], off_x};
      end
      default: begin
        px = {off_x[PW], off_x};
        py = {off_y[PW], off_y};
      end
    endcase
    pre_nxt.vld = ang_vld_r;
    pre_nxt.x   = {{XPAD{px[PW+1]}}, px, 8'b0};
    pre_nxt.y   = {{XPAD{py[PW+1]}}, py, 8'b0};
    pre_nxt.z   = {{(ZW-AW){res[AW-1]}}, res};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain[0].vld <= 1'b0;
    end else if (adv) begin
      chain[0].vld <= pre_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chain[0].x <= pre_nxt.x;
      chain[0].y <= pre_nxt.y;
      chain[0].z <= pre_nxt.z;
    end
  end

  // ---- cordic cell chain ----
  for (genvar i = 0; i < NS; i++) begin : g_cell
    sopg_cell #(
      .STAGE(i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  // ---- gain, scale, pivot and clamp ----
  sopg_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .d_in     (chain[NS]),
    .scale    (scale_r),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .fin_vld  (fin_vld),
    .fin      (fin)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= fin;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ----- design/sopg_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sopg_cell: one cordic micro-rotation
// rotates x/y by the fixed arctangent of its stage toward zero residual angle
// ----------------------------------------------------------------------------
module sopg_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  sopg_pkg::cordic_t d_in,
  output sopg_pkg::cordic_t d_out
);
  import sopg_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = {{(ZW-30){1'b0}}, ATAN_TURN[STAGE]};

  logic signed [XW-1:0] xs, ys;
  cordic_t              d_nxt;
  cordic_t              d_r;

  always_comb begin
    xs = $signed(d_in.x) >>> STAGE;
    ys = $signed(d_in.y) >>> STAGE;
    d_nxt.vld = d_in.vld;
    if (!d_in.z[ZW-1]) begin
      d_nxt.x = $signed(d_in.x) - ys;
      d_nxt.y = $signed(d_in.y) + xs;
      d_nxt.z = $signed(d_in.z) - ATAN;
    end else begin
      d_nxt.x = $signed(d_in.x) + ys;
      d_nxt.y = $signed(d_in.y) - xs;
      d_nxt.z = $signed(d_in.z) + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r.vld <= d_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r.x <= d_nxt.x;
      d_r.y <= d_nxt.y;
      d_r.z <= d_nxt.z;
    end
  end

  assign d_out = d_r;

endmodule

// ----- design/sopg_post.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sopg_post: gain correction, scaling and pivot offset
// two multiply stages, then round, add the pivot and clamp to Q16.8
// ----------------------------------------------------------------------------
module sopg_post (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  sopg_pkg::cordic_t                 d_in,
  input  logic signed [sopg_pkg::SW-1:0]    scale,
  input  logic signed [sopg_pkg::PW-1:0]    center_x,
  input  logic signed [sopg_pkg::PW-1:0]    center_y,
  output logic                              fin_vld,
  output sopg_pkg::out_item_t               fin
);
  import sopg_pkg::*;

  localparam int GPW = XW + 25;
  localparam int SPW = GW + SW;
  localparam int RW  = SPW - 16;
  localparam int FW  = RW + 1;
  localparam logic signed [GPW-1:0] GRND = GPW'(64'h8000_0000);
  localparam logic signed [SPW-1:0] SRND = SPW'(32768);
  localparam logic signed [FW-1:0]  PMAX = FW'(8388607);
  localparam logic signed [FW-1:0]  PMIN = -FW'(8388608);

  logic signed [GPW-1:0] gx_p, gy_p;
  logic signed [GW-1:0]  gx_nxt, gy_nxt, gx_r, gy_r;
  logic                  g_vld_r;
  logic signed [SPW-1:0] sx_r, sy_r;
  logic                  s_vld_r;
  logic signed [SPW-1:0] sx_rnd, sy_rnd;
  logic signed [FW-1:0]  fx, fy;

  // gain correction drops the 8 guard bits, rounding half up
  always_comb begin
    gx_p   = $signed(d_in.x) * GAIN_Q24;
    gy_p   = $signed(d_in.y) * GAIN_Q24;
    gx_nxt = GW'((gx_p + GRND) >>> 32);
    gy_nxt = GW'((gy_p + GRND) >>> 32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= d_in.vld;
      s_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
      sx_r <= gx_r * scale;
      sy_r <= gy_r * scale;
    end
  end

  always_comb begin
    sx_rnd = (sx_r + SRND) >>> 16;
    sy_rnd = (sy_r + SRND) >>> 16;
    fx = FW'($signed(sx_rnd[RW-1:0])) + FW'(center_x);
    fy = FW'($signed(sy_rnd[RW-1:0])) + FW'(center_y);
    if (fx > PMAX) begin
      fin.pos_x = PMAX[PW-1:0];
    end else if (fx < PMIN) begin
      fin.pos_x = PMIN[PW-1:0];
    end else begin
      fin.pos_x = fx[PW-1:0];
    end
    if (fy > PMAX) begin
      fin.pos_y = PMAX[PW-1:0];
    end else if (fy < PMIN) begin
      fin.pos_y = PMIN[PW-1:0];
    end else begin
      fin.pos_y = fy[PW-1:0];
    end
  end

  assign fin_vld = s_vld_r;

endmodule

// ----- dv/spiral_orbit_position_generator_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiral_orbit_position_generator_unit_test: self-checking bench for the orbit
// position generator
// drives frame ticks and restarts through the valid/ready input channel and
// programs pivot, start point, angle and scale steps between runs of ticks.
// Each position leaving the block is compared with a bit-true fixed-point
// model of the quadrant fold, the cordic rotation, the gain correction and
// the scaling kept inside this bench
// ----------------------------------------------------------------------------
module spiral_orbit_position_generator_unit_test;
  import sopg_pkg::*;

  // instance setup and run limits
  localparam int          CORDIC_STAGES = 16;
  localparam int          ARCTAN_ROWS   = 24;     // stages past this are skipped
  localparam int          RANDOM_TICKS  = 1750;
  localparam int          TAIL_CYCLES   = 40;     // longer than the whole path from tick to output
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  // index that no register answers to
  localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;

  // fixed-point constants of the position math
  localparam longint      GAIN_INV_Q24 = 64'sd10188014;   // 1/K, Q.24
  localparam longint      GAIN_ROUND   = 64'sd2147483648; // half lsb before >>> 32
  localparam longint      SCALE_HI     = 64'sd2147483647;
  localparam longint      SCALE_LO     = -64'sd2147483648;
  localparam longint      POS_HI       = 64'sd8388607;
  localparam longint      POS_LO       = -64'sd8388608;
  localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;
  localparam logic signed [SW-1:0] UNITY_Q16 = 32'sd65536;

  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

  // one line of the directed table: a register write or a tick, with the
  // position typed in where it is obvious
  typedef struct {
    row_kind_t         kind;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;
    logic              restart;
    logic              check;
    out_item_t         want;
  } script_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  sopg_chan_if #(.payload_t(in_item_t))  in_ch ();
  sopg_chan_if #(.payload_t(out_item_t)) out_ch ();

  spiral_orbit_position_generator_unit #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // model copy of the registers and the orbit state
  logic signed [PW-1:0] pivot_x, pivot_y, origin_x, origin_y;
  logic        [AW-1:0] turn_step;
  logic signed [SW-1:0] grow_step;
  logic                 reverse_dir;
  logic        [AW-1:0] tick_count;
  logic signed [SW-1:0] scale_q16;
  longint               arctan_step [ARCTAN_ROWS];

  out_item_t   pos_expected [$];
  script_row_t script [$];

  // bookkeeping
  int          ticks_sent;
  int          results_seen;
  int          restarts_sent;
  int          writes_done;
  int          mismatches;
  int unsigned cycles;

  // sender burst shaping
  int burst_left;
  int gap_len;

  // receiver stall pattern
  int rx_mode;
  int rx_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // arctangent of 2^-i in 2^-32 turn units, rounded to nearest
  initial begin
    for (int i = 0; i < ARCTAN_ROWS; i++) begin
      arctan_step[i] = longint'($atan(2.0 ** (-i)) * 4294967296.0 / (8.0 * $atan(1.0)));
    end
  end

  // saturate a position to signed Q16.8
  function automatic logic signed [PW-1:0] clamp_pos(input longint v);
    if (v > POS_HI) return POS_HI[PW-1:0];
    if (v < POS_LO) return POS_LO[PW-1:0];
    return v[PW-1:0];
  endfunction

  // mirror of a register write; unknown indexes fall through
  function automatic void apply_reg(input logic [CFG_IW-1:0] idx,
                                    input logic [CFG_DW-1:0] data);
    case (idx)
      REG_CENTER_X:   pivot_x     = data[PW-1:0];
      REG_CENTER_Y:   pivot_y     = data[PW-1:0];
      REG_START_X:    origin_x    = data[PW-1:0];
      REG_START_Y:    origin_y    = data[PW-1:0];
      REG_ANGLE_STEP: turn_step   = data;
      REG_SCALE_STEP: grow_step   = data;
      REG_CLOCKWISE:  reverse_dir = data[0];
      default: ;
    endcase
  endfunction

  // step the orbit state for one tick and return the position it lands on
  function automatic out_item_t advance_orbit(input logic restart);
    longint      sum, ox, oy, oz, xs, ys, hold;
    logic [31:0] angle, quad, resid;
    int          i;
    out_item_t   res;
    if (restart) begin
      tick_count = '0;
      scale_q16  = UNITY_Q16;
    end else begin
      sum = longint'(scale_q16) + longint'(grow_step);
      if (sum > SCALE_HI) sum = SCALE_HI;
      else if (sum < SCALE_LO) sum = SCALE_LO;
      scale_q16  = sum[31:0];
      tick_count = reverse_dir ? tick_count - 32'd1 : tick_count + 32'd1;
    end

    // angle wraps with the count; fold into a quadrant and a residual of
    // at most an eighth of a turn either way
    angle = tick_count * turn_step;
    quad  = (angle + EIGHTH_TURN) >> 30;
    resid = angle - (quad << 30);
    oz    = longint'($signed(resid));

    // offset with 8 guard bits
    ox = (longint'(origin_x) - longint'(pivot_x)) * 256;
    oy = (longint'(origin_y) - longint'(pivot_y)) * 256;

    case (quad[1:0])
      2'd1: begin
        hold = ox;
        ox   = -oy;
        oy   = hold;
      end
      2'd2: begin
        ox = -ox;
        oy = -oy;
      end
      2'd3: begin
        hold = ox;
        ox   = oy;
        oy   = -hold;
      end
      default: ;
    endcase

    for (i = 0; i < CORDIC_STAGES && i < ARCTAN_ROWS; i++) begin
      xs = ox >>> i;
      ys = oy >>> i;
      if (oz >= 0) begin
        ox = ox - ys;
        oy = oy + xs;
        oz = oz - arctan_step[i];
      end else begin
        ox = ox + ys;
        oy = oy - xs;
        oz = oz + arctan_step[i];
      end
    end

    // drop gain and guard bits, then scale and move back to the pivot
    ox = (ox * GAIN_INV_Q24 + GAIN_ROUND) >>> 32;
    oy = (oy * GAIN_INV_Q24 + GAIN_ROUND) >>> 32;
    ox = ((ox * longint'(scale_q16) + 32768) >>> 16) + longint'(pivot_x);
    oy = ((oy * longint'(scale_q16) + 32768) >>> 16) + longint'(pivot_y);

    res.pos_x = clamp_pos(ox);
    res.pos_y = clamp_pos(oy);
    return res;
  endfunction

  // directed table builders
  function automatic void add_write(input logic [CFG_IW-1:0] idx,
                                    input logic [CFG_DW-1:0] data);
    script_row_t row;
    row = '{kind: ROW_WRITE, index: idx, data: data, restart: 1'b0,
            check: 1'b0, want: '0};
    script.push_back(row);
  endfunction

  function automatic void add_tick(input logic restart, input logic check,
                                   input int want_x, input int want_y);
    script_row_t row;
    row = '{kind: ROW_TICK, index: '0, data: '0, restart: restart,
            check: check, want: '0};
    row.want.pos_x = want_x[PW-1:0];
    row.want.pos_y = want_y[PW-1:0];
    script.push_back(row);
  endfunction

  // random register contents, weighted toward extremes and small values
  function automatic logic [CFG_DW-1:0] pick_reg_value(input logic [CFG_IW-1:0] idx);
    logic [CFG_DW-1:0] r;
    r = $urandom();
    case (idx)
      REG_ANGLE_STEP: begin
        case ($urandom_range(0, 5))
          0: r = 32'h7FFF_FFFF;
          1: r = 32'h8000_0000;
          2: r = {3'($urandom_range(0, 7)), 29'd0};          // eighth-turn multiples
          3: r = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
          default: ;
        endcase
      end
      REG_SCALE_STEP: begin
        case ($urandom_range(0, 6))
          0: r = 32'h7FFF_FFFF;
          1: r = 32'h8000_0000;
          2: r = '0;
          3: r = r;
          default: r = $urandom_range(0, 8192) - 4096;       // slow spiral
        endcase
      end
      REG_CLOCKWISE: ;
      default: begin
        case ($urandom_range(0, 7))
          0: r[PW-1:0] = 24'h7F_FFFF;
          1: r[PW-1:0] = 24'h80_0000;
          2: r[PW-1:0] = '0;
          3, 4: r[PW-1:0] = PW'($urandom_range(0, 65535) - 32768);
          default: ;
        endcase
      end
    endcase
    return r;
  endfunction

  // one register write; the enable stays up so that writes can run back to
  // back, the caller drops it
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
    writes_done++;
  endtask

  // hand one tick to the block; valid stays up when another follows in the
  // same burst
  task automatic send_tick(input logic restart, input logic hold,
                           input logic check, input out_item_t typed);
    out_item_t want;
    in_ch.valid <= 1'b1;
    in_ch.data  <= in_item_t'(restart);
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    want = advance_orbit(restart);
    if (check) want = typed;
    pos_expected.push_back(want);
    ticks_sent++;
    if (restart) restarts_sent++;

    // bursts of random length with random gaps, some of them empty
    gap_len = 0;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end
    if (gap_len != 0 || !hold) in_ch.valid <= 1'b0;
    repeat (gap_len) @(posedge clk);
  endtask

  // registers only change with nothing in flight
  task automatic wait_idle();
    while (results_seen != ticks_sent) @(posedge clk);
  endtask

  // receiver: modes of full rate, light stalls, heavy stalls and a long hold
  initial begin
    out_ch.ready = 1'b0;
    rx_mode      = 0;
    rx_left      = 0;
    forever begin
      @(posedge clk);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (rx_left % 24) < 4;       // long holds, short openings
      endcase
    end
  end

  // result checker: every transfer on the output must match the oldest tick
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (pos_expected.size() == 0) begin
        $error("position transfer with no tick waiting: x %0d y %0d",
               out_ch.data.pos_x, out_ch.data.pos_y);
        mismatches++;
      end else begin
        out_item_t want;
        want = pos_expected.pop_front();
        if (out_ch.data.pos_x !== want.pos_x) begin
          $error("pos_x: expected %0d, got %0d", want.pos_x, out_ch.data.pos_x);
          mismatches++;
        end
        if (out_ch.data.pos_y !== want.pos_y) begin
          $error("pos_y: expected %0d, got %0d", want.pos_y, out_ch.data.pos_y);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : main_flow
    int   row;
    int   k;
    int   n_ticks;
    int   random_ticks;
    int   phases;
    logic writing;
    logic hold;
    logic rs;

    // everything known before the first edge
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    ticks_sent    = 0;
    results_seen  = 0;
    restarts_sent = 0;
    writes_done   = 0;
    mismatches    = 0;
    cycles        = 0;
    burst_left    = 0;
    gap_len       = 0;
    random_ticks  = 0;
    phases        = 0;
    writing       = 1'b0;

    // model state after reset
    pivot_x     = '0;
    pivot_y     = '0;
    origin_x    = '0;
    origin_y    = '0;
    turn_step   = '0;
    grow_step   = '0;
    reverse_dir = 1'b0;
    tick_count  = '0;
    scale_q16   = UNITY_Q16;

    // all registers zero: offset is zero so the pivot comes back
    add_tick(1'b0, 1'b1, 0, 0);
    add_tick(1'b1, 1'b1, 0, 0);
    // start on top of the pivot at the corners of the range, junk in the
    // upper data bits
    add_write(REG_CENTER_X, 32'h007F_FFFF);
    add_write(REG_CENTER_Y, 32'hFF80_0000);
    add_write(REG_START_X,  32'hA57F_FFFF);
    add_write(REG_START_Y,  32'h0080_0000);
    add_tick(1'b0, 1'b1, 8388607, -8388608);
    // largest offset with scale running into its positive ceiling
    add_write(REG_CENTER_X,   32'hFF00_0000);
    add_write(REG_CENTER_Y,   32'h0000_0000);
    add_write(REG_START_Y,    32'h007F_FFFF);
    add_write(REG_SCALE_STEP, 32'h7FFF_FFFF);
    add_tick(1'b0, 1'b1, 8388607, 8388607);
    add_tick(1'b0, 1'b1, 8388607, 8388607);
    // most negative offset, scale driven through zero into its floor
    add_write(REG_START_X,    32'h0080_0000);
    add_write(REG_START_Y,    32'h0080_0000);
    add_write(REG_SCALE_STEP, 32'h8000_0000);
    add_tick(1'b1, 1'b0, 0, 0);
    add_tick(1'b0, 1'b1, 8388607, 8388607);
    add_tick(1'b0, 1'b1, 8388607, 8388607);
    // quarter turns clockwise, count wraps below zero; the unused index
    // must leave everything alone
    add_write(REG_SCALE_STEP, 32'h0000_0000);
    add_write(REG_START_X,    32'h0000_1000);
    add_write(REG_START_Y,    32'hFFFF_F800);
    add_write(REG_ANGLE_STEP, 32'h4000_0000);
    add_write(REG_CLOCKWISE,  32'hFFFF_FFFF);
    add_write(REG_UNUSED,     32'hFFFF_FFFF);
    add_tick(1'b1, 1'b0, 0, 0);
    for (k = 0; k < 4; k++) add_tick(1'b0, 1'b0, 0, 0);
    // eighth turns sit right on the quadrant fold
    add_write(REG_ANGLE_STEP, 32'h2000_0000);
    add_write(REG_CLOCKWISE,  32'hFFFF_FFFE);
    add_tick(1'b1, 1'b0, 0, 0);
    for (k = 0; k < 3; k++) add_tick(1'b0, 1'b0, 0, 0);
    // half turn and the largest positive step, the last with a growing scale
    add_write(REG_ANGLE_STEP, 32'h8000_0000);
    add_tick(1'b0, 1'b0, 0, 0);
    add_tick(1'b0, 1'b0, 0, 0);
    add_write(REG_ANGLE_STEP, 32'h7FFF_FFFF);
    add_write(REG_SCALE_STEP, 32'h0000_8000);
    add_tick(1'b0, 1'b0, 0, 0);
    add_tick(1'b0, 1'b0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (row = 0; row < script.size(); row++) begin
      if (script[row].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(script[row].index, script[row].data);
        writing = 1'b1;
      end else begin
        if (writing) begin
          cfg_we <= 1'b0;
          writing = 1'b0;
        end
        hold = (row + 1 < script.size()) && (script[row + 1].kind == ROW_TICK);
        send_tick(script[row].restart, hold, script[row].check, script[row].want);
      end
    end

    // random settings, each followed by a run of ticks that mostly advance
    // and now and then restart
    while (random_ticks < RANDOM_TICKS) begin
      wait_idle();
      for (k = 0; k < 7; k++) write_reg(3'(k), pick_reg_value(3'(k)));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom());
      cfg_we <= 1'b0;
      phases++;
      n_ticks = $urandom_range(10, 90);
      for (k = 0; k < n_ticks; k++) begin
        rs = (k == 0) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 15) == 0);
        send_tick(rs, k + 1 < n_ticks, 1'b0, '0);
      end
      random_ticks += n_ticks;
    end

    // drain, then give any stray result time to show up
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pos_expected.size() != 0) begin
      $error("%0d positions never came out", pos_expected.size());
      mismatches++;
    end

    $display("ran %0d ticks (%0d restarts) across %0d random settings, %0d writes",
             ticks_sent, restarts_sent, phases, writes_done);
    $display("checked %0d positions in %0d cycles, %0d mismatches",
             results_seen, cycles, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
